@@ design/bqf_pkg.sv @@
`default_nettype none

package bqf_pkg;

  localparam int MAX_TAPS = 32;
  localparam int TAP_AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TAP_CW   = $clog2(MAX_TAPS + 1);

  localparam int SAMPLE_W = 16;
  localparam int COEFF_W  = 18;
  localparam int GAIN_W   = 17;
  localparam int TAPS_W   = 6;
  localparam int IDX_W    = 5;
  localparam int OUT_W    = 24;
  localparam int CFG_IW   = 3;

  // shared multiplier: 24-bit signed by 18-bit signed
  localparam int MUL_AW   = 24;
  localparam int MUL_BW   = 18;
  localparam int PROD_W   = MUL_AW + MUL_BW;
  localparam int ACC_W    = 64;
  localparam int SUM_W    = 45;
  localparam int LO_W     = 23;
  localparam int HI_W     = SUM_W - LO_W;

  localparam int W_SHIFT  = 14;
  localparam int Y_SHIFT  = 28;

  localparam logic signed [ACC_W-1:0] W_HALF  = ACC_W'(64'sd8192);
  localparam logic signed [ACC_W-1:0] Y_HALF  = ACC_W'(64'sd134217728);
  localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(64'sd8388607);
  localparam logic signed [ACC_W-1:0] OUT_MIN = -ACC_W'(64'sd8388608);

  localparam logic [CFG_IW-1:0] REG_TAPS = 3'd0;
  localparam logic [CFG_IW-1:0] REG_B0   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_B1   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_B2   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_A1   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_A2   = 3'd5;
  localparam logic [CFG_IW-1:0] REG_GAIN = 3'd6;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEFF  = 1'b1;

  typedef enum logic [1:0] {
    MAC_NONE,
    MAC_ADD,
    MAC_SUB,
    MAC_ADD_HI
  } mac_op_t;

  typedef struct packed {
    mac_op_t op;
    logic    acc_set;
  } mac_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IIR_A1,
    ST_IIR_A2,
    ST_IIR_W,
    ST_IIR_RND,
    ST_IIR_B0,
    ST_IIR_B1,
    ST_IIR_B2,
    ST_FIR,
    ST_SUM_WAIT,
    ST_GAIN_HI,
    ST_GAIN_LO,
    ST_GAIN_ACC,
    ST_ROUND,
    ST_OUT
  } state_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > OUT_MAX) begin
      r = OUT_MAX[OUT_W-1:0];
    end else if (v < OUT_MIN) begin
      r = OUT_MIN[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/bqf_ram.sv @@
`default_nettype none

module bqf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic                   re,
  input  wire logic [AW-1:0]          raddr,
  output      logic [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/bqf_mac.sv @@
`default_nettype none

module bqf_mac
  import bqf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire mac_ctrl_t                ctrl,
  input  wire logic signed [MUL_AW-1:0] mul_a,
  input  wire logic signed [MUL_BW-1:0] mul_b,
  input  wire logic signed [ACC_W-1:0]  acc_init,
  output      logic signed [ACC_W-1:0]  acc
);

  logic signed [PROD_W-1:0] prod;
  mac_op_t                  prod_op;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  term;

  assign prod_ext = ACC_W'(prod);

  always_comb begin
    unique case (prod_op)
      MAC_ADD:    term = prod_ext;
      MAC_SUB:    term = -prod_ext;
      MAC_ADD_HI: term = prod_ext <<< LO_W;
      default:    term = '0;
    endcase
  end

  // the product is registered and lands in the cycle after its operands, where it is folded in
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_op <= MAC_NONE;
    end else begin
      prod_op <= ctrl.op;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (ctrl.acc_set) begin
      acc <= acc_init;
    end else begin
      acc <= acc + term;
    end
  end

endmodule

`default_nettype wire

@@ design/iir_biquad_or_fir_filter_core.sv @@
// Biquad IIR / FIR filter core.
// Input channel s_*: one word per item. s_tuser is the kind: 0 filters the sample in
// s_tdata, 1 writes one FIR coefficient into the coefficient memory (no result word).
// Output channel m_*: one word per sample with the filtered value and its difference
// from the previous filtered value, both saturated to 24 bits.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index (0 tap count,
// 1..3 b0..b2, 4..5 a1..a2, 6 output gain); write only while the core is idle.
// With tap count 0 the core runs one direct-form-II section; otherwise an N-tap FIR
// (N capped at 32) walks the delay and coefficient memories one tap per cycle through
// a single shared 24x18 multiply-accumulate, shifting the delay line as it goes.
// A sample steps through the IIR or FIR states, then the gain and rounding states, and
// waits in ST_OUT while the output register holds an untaken word; the result is on
// m_tvalid the cycle after it leaves ST_OUT. A coefficient write keeps the core idle.
// Reset loads the configuration defaults, clears the biquad state, the last output and
// both memories' valid bits, so unwritten entries read as zero; no clearing pass is needed.
// The finished word sits in an output register, so the next item is accepted while it
// waits; a stalled receiver holds only the following result, in its final cycle.
`default_nettype none

module iir_biquad_or_fir_filter_core
  import bqf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output      logic              s_tready,
  input  wire logic [39:0]       s_tdata,   // sample[15:0], coeff_index[20:16], coeff_value[38:21]
  input  wire logic              s_tuser,   // kind
  output      logic              m_tvalid,
  input  wire logic              m_tready,
  output      logic [47:0]       m_tdata,   // filtered[23:0], difference[47:24]
  input  wire logic              cfg_wr_en,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [17:0]       cfg_data
);

  // configuration
  logic [TAPS_W-1:0]         taps_in_use;
  logic signed [COEFF_W-1:0] feedforward_b0, feedforward_b1, feedforward_b2;
  logic signed [COEFF_W-1:0] feedback_a1, feedback_a2;
  logic [GAIN_W-1:0]         output_gain;

  // input fields
  logic                      kind;
  logic signed [SAMPLE_W-1:0] sample;
  logic [IDX_W-1:0]          coeff_index;
  logic signed [COEFF_W-1:0] coeff_value;

  assign kind        = s_tuser;
  assign sample      = s_tdata[15:0];
  assign coeff_index = s_tdata[20:16];
  assign coeff_value = s_tdata[38:21];

  state_t state, state_next;

  // biquad state and sequencing registers
  logic signed [OUT_W-1:0]    w1, w2, w_new;
  logic [TAP_CW-1:0]          n_reg, n_in, rd_idx;
  logic                       pend;
  logic [TAP_AW-1:0]          wr_addr;
  logic signed [SAMPLE_W-1:0] carry;
  logic [LO_W-1:0]            sum_lo;
  logic signed [OUT_W-1:0]    y_reg, previous_output;
  logic [MAX_TAPS-1:0]        dly_vld, cof_vld;
  logic                       dly_vld_q, cof_vld_q;

  // output register
  logic                       out_valid;
  logic signed [OUT_W-1:0]    out_filtered, out_difference;

  // mac and memory hookup
  mac_ctrl_t                  mctl;
  logic signed [MUL_AW-1:0]   mul_a;
  logic signed [MUL_BW-1:0]   mul_b;
  logic signed [ACC_W-1:0]    acc_init, acc;
  logic                       rd_en, dly_we, cof_we, idx_ok;
  logic [TAP_AW-1:0]          rd_addr;
  logic [SAMPLE_W-1:0]        dly_q;
  logic [COEFF_W-1:0]         cof_q;
  logic signed [SAMPLE_W-1:0] dly_word;
  logic signed [COEFF_W-1:0]  cof_word;
  logic signed [ACC_W-1:0]    w_rnd, y_rnd;
  logic signed [OUT_W:0]      diff_wide;
  logic signed [OUT_W-1:0]    diff_sat;
  logic signed [HI_W-1:0]     sum_hi;

  assign n_in     = (int'(taps_in_use) > MAX_TAPS) ? TAP_CW'(MAX_TAPS) : TAP_CW'(taps_in_use);
  assign idx_ok   = int'(coeff_index) < MAX_TAPS;
  assign rd_addr  = rd_idx[TAP_AW-1:0];
  assign dly_word = dly_vld_q ? signed'(dly_q) : '0;
  assign cof_word = cof_vld_q ? signed'(cof_q) : '0;
  assign w_rnd    = (acc + W_HALF) >>> W_SHIFT;
  assign y_rnd    = (acc + Y_HALF) >>> Y_SHIFT;
  assign w_new    = sat_out(w_rnd);
  assign sum_hi   = acc[SUM_W-1:LO_W];

  assign diff_wide = {y_reg[OUT_W-1], y_reg} - {previous_output[OUT_W-1], previous_output};
  assign diff_sat  = (diff_wide[OUT_W] != diff_wide[OUT_W-1])
                   ? {diff_wide[OUT_W], {(OUT_W-1){~diff_wide[OUT_W]}}}
                   : diff_wide[OUT_W-1:0];

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_difference, out_filtered};

  bqf_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (mctl),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .acc_init (acc_init),
    .acc      (acc)
  );

  bqf_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_dly_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (wr_addr),
    .wdata (carry),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (dly_q)
  );

  bqf_ram #(.WIDTH(COEFF_W), .DEPTH(MAX_TAPS)) u_cof_ram (
    .clk   (clk),
    .we    (cof_we),
    .waddr (TAP_AW'(coeff_index)),
    .wdata (coeff_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (cof_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    mctl.op      = MAC_NONE;
    mctl.acc_set = 1'b0;
    acc_init     = '0;
    mul_a        = '0;
    mul_b        = '0;
    rd_en        = 1'b0;
    dly_we       = 1'b0;
    cof_we       = 1'b0;
    s_tready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (kind == KIND_COEFF) begin
            cof_we = idx_ok;
          end else begin
            mctl.acc_set = 1'b1;
            if (n_in == '0) begin
              acc_init   = ACC_W'(sample) <<< W_SHIFT;
              state_next = ST_IIR_A1;
            end else begin
              state_next = ST_FIR;
            end
          end
        end
      end
      ST_IIR_A1: begin
        mul_a      = w1;
        mul_b      = feedback_a1;
        mctl.op    = MAC_SUB;
        state_next = ST_IIR_A2;
      end
      ST_IIR_A2: begin
        mul_a      = w2;
        mul_b      = feedback_a2;
        mctl.op    = MAC_SUB;
        state_next = ST_IIR_W;
      end
      ST_IIR_W: begin
        state_next = ST_IIR_RND;
      end
      ST_IIR_RND: begin
        mctl.acc_set = 1'b1;
        state_next   = ST_IIR_B0;
      end
      ST_IIR_B0: begin
        mul_a      = y_reg;
        mul_b      = feedforward_b0;
        mctl.op    = MAC_ADD;
        state_next = ST_IIR_B1;
      end
      ST_IIR_B1: begin
        mul_a      = w1;
        mul_b      = feedforward_b1;
        mctl.op    = MAC_ADD;
        state_next = ST_IIR_B2;
      end
      ST_IIR_B2: begin
        mul_a      = w2;
        mul_b      = feedforward_b2;
        mctl.op    = MAC_ADD;
        state_next = ST_SUM_WAIT;
      end
      ST_FIR: begin
        rd_en = rd_idx < n_reg;
        if (pend) begin
          // write the shifted-in word back and multiply it by its tap
          dly_we  = 1'b1;
          mul_a   = MUL_AW'(carry);
          mul_b   = cof_word;
          mctl.op = MAC_ADD;
          if (!rd_en) begin
            state_next = ST_SUM_WAIT;
          end
        end
      end
      ST_SUM_WAIT: begin
        state_next = ST_GAIN_HI;
      end
      ST_GAIN_HI: begin
        mul_a        = MUL_AW'(sum_hi);
        mul_b        = MUL_BW'(output_gain);
        mctl.op      = MAC_ADD_HI;
        mctl.acc_set = 1'b1;
        state_next   = ST_GAIN_LO;
      end
      ST_GAIN_LO: begin
        mul_a      = MUL_AW'(sum_lo);
        mul_b      = MUL_BW'(output_gain);
        mctl.op    = MAC_ADD;
        state_next = ST_GAIN_ACC;
      end
      ST_GAIN_ACC: begin
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      taps_in_use     <= '0;
      feedforward_b0  <= '0;
      feedforward_b1  <= '0;
      feedforward_b2  <= COEFF_W'(18'sd16384);
      feedback_a1     <= '0;
      feedback_a2     <= '0;
      output_gain     <= GAIN_W'(17'd16384);
      w1              <= '0;
      w2              <= '0;
      previous_output <= '0;
      dly_vld         <= '0;
      cof_vld         <= '0;
      pend            <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_TAPS: taps_in_use    <= cfg_data[TAPS_W-1:0];
          REG_B0:   feedforward_b0 <= cfg_data;
          REG_B1:   feedforward_b1 <= cfg_data;
          REG_B2:   feedforward_b2 <= cfg_data;
          REG_A1:   feedback_a1    <= cfg_data;
          REG_A2:   feedback_a2    <= cfg_data;
          REG_GAIN: output_gain    <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (cof_we) begin
        cof_vld[TAP_AW'(coeff_index)] <= 1'b1;
      end
      if (dly_we) begin
        dly_vld[wr_addr] <= 1'b1;
      end
      if (state == ST_IIR_B2) begin
        w1 <= y_reg;
        w2 <= w1;
      end
      if (state == ST_FIR) begin
        pend <= rd_en;
      end else begin
        pend <= 1'b0;
      end
      if (state == ST_OUT && (!out_valid || m_tready)) begin
        out_valid       <= 1'b1;
        previous_output <= y_reg;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      dly_vld_q <= dly_vld[rd_addr];
      cof_vld_q <= cof_vld[rd_addr];
      rd_idx    <= rd_idx + TAP_CW'(1);
    end
    if (state == ST_FIR) begin
      wr_addr <= rd_addr;
      if (pend) begin
        carry <= dly_word;
      end
    end
    if (state == ST_IDLE) begin
      n_reg  <= n_in;
      rd_idx <= '0;
      carry  <= sample;
    end
    // y_reg holds the new biquad state w before it carries the output
    if (state == ST_IIR_RND) begin
      y_reg <= w_new;
    end
    if (state == ST_ROUND) begin
      y_reg <= sat_out(y_rnd);
    end
    if (state == ST_GAIN_HI) begin
      sum_lo <= acc[LO_W-1:0];
    end
    if (state == ST_OUT && (!out_valid || m_tready)) begin
      out_filtered   <= y_reg;
      out_difference <= diff_sat;
    end
  end

endmodule

`default_nettype wire

@@ verif/bqf_filter_checker.sv @@
module bqf_filter_checker
  import bqf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  input  wire logic              s_tready,
  input  wire logic [39:0]       s_tdata,   // sample[15:0], coeff_index[20:16], coeff_value[38:21]
  input  wire logic              s_tuser,   // kind
  input  wire logic              m_tvalid,
  input  wire logic              m_tready,
  input  wire logic [47:0]       m_tdata,   // filtered[23:0], difference[47:24]
  input  wire logic              cfg_wr_en,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [17:0]       cfg_data,
  output int                     mismatches,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [OUT_W-1:0] difference;
    logic signed [OUT_W-1:0] filtered;
  } filter_word_t;

  logic [TAPS_W-1:0]          tap_count;
  logic signed [COEFF_W-1:0]  b0, b1, b2, a1, a2;
  logic [GAIN_W-1:0]          gain;
  logic signed [OUT_W-1:0]    w1, w2, last_y;
  logic signed [SAMPLE_W-1:0] fir_line [MAX_TAPS];
  logic signed [COEFF_W-1:0]  fir_taps [MAX_TAPS];
  filter_word_t               expected_words [$];

  function automatic logic signed [OUT_W-1:0] clamp24(input longint v);
    if (v > 64'sd8388607) begin
      return 24'sh7fffff;
    end else if (v < -64'sd8388608) begin
      return 24'sh800000;
    end
    return v[OUT_W-1:0];
  endfunction

  // Advance the filter state by one sample and return the word it must produce.
  function automatic filter_word_t filter_sample(input logic signed [SAMPLE_W-1:0] x);
    longint       acc, w, sum, y;
    int           n, i;
    filter_word_t r;
    n = (tap_count > MAX_TAPS) ? MAX_TAPS : int'(tap_count);
    if (n == 0) begin
      // biquad: w rounds half up from Q14, sum stays in Q14
      acc = longint'(x) * 16384 - longint'(a1) * longint'(w1) - longint'(a2) * longint'(w2);
      w = clamp24((acc + 8192) >>> 14);
      sum = longint'(b0) * w + longint'(b1) * longint'(w1) + longint'(b2) * longint'(w2);
      w2 = w1;
      w1 = w[OUT_W-1:0];
    end else begin
      // shift only the taps in use; the rest keep their contents
      for (i = n - 1; i > 0; i--) begin
        fir_line[i] = fir_line[i-1];
      end
      fir_line[0] = x;
      sum = 0;
      for (i = 0; i < n; i++) begin
        sum += longint'(fir_line[i]) * longint'(fir_taps[i]);
      end
    end
    y = clamp24((sum * longint'(gain) + 134217728) >>> 28);
    r.filtered = y[OUT_W-1:0];
    r.difference = clamp24(y - longint'(last_y));
    last_y = r.filtered;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at %0t: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin : track
    filter_word_t got, want;
    if (rst) begin
      tap_count = '0;
      b0 = '0;
      b1 = '0;
      b2 = 18'sd16384;
      a1 = '0;
      a2 = '0;
      gain = 17'd16384;
      w1 = '0;
      w2 = '0;
      last_y = '0;
      foreach (fir_line[i]) begin
        fir_line[i] = '0;
        fir_taps[i] = '0;
      end
      expected_words.delete();
    end else begin
      // compare before predicting: a word leaving now belongs to an older sample
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word filtered=%0d difference=%0d",
                                    got.filtered, got.difference));
        end else begin
          want = expected_words.pop_front();
          if (got.filtered !== want.filtered) begin
            report_mismatch($sformatf("filtered got %0d want %0d",
                                      got.filtered, want.filtered));
          end
          if (got.difference !== want.difference) begin
            report_mismatch($sformatf("difference got %0d want %0d",
                                      got.difference, want.difference));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == KIND_COEFF) begin
          if (s_tdata[20:16] < MAX_TAPS) begin
            fir_taps[s_tdata[20:16]] = s_tdata[38:21];
          end
        end else begin
          expected_words.push_back(filter_sample(s_tdata[15:0]));
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TAPS: tap_count = cfg_data[TAPS_W-1:0];
          REG_B0:   b0 = cfg_data;
          REG_B1:   b1 = cfg_data;
          REG_B2:   b2 = cfg_data;
          REG_A1:   a1 = cfg_data;
          REG_A2:   a2 = cfg_data;
          REG_GAIN: gain = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= expected_words.size();
  end

endmodule

@@ verif/iir_biquad_or_fir_filter_core_test.sv @@
module iir_biquad_or_fir_filter_core_test
  import bqf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IW-1:0] REG_UNUSED = 3'd7;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_PHASES = 16;
  localparam int PHASE_ITEMS   = 100;

  logic              clk = 1'b0;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [39:0]       s_tdata;
  logic              s_tuser;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [47:0]       m_tdata;
  logic              cfg_wr_en;
  logic [CFG_IW-1:0] cfg_index;
  logic [17:0]       cfg_data;
  int                send_idle_pct = 8;
  int                recv_idle_pct = 48;
  int                mismatches;
  int                outstanding;

  iir_biquad_or_fir_filter_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bqf_filter_checker filter_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_word(input logic kind, input logic [39:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // unused fields get random bits so they toggle too; bit 39 stays zero
  task automatic send_sample(input logic signed [15:0] x);
    send_word(KIND_SAMPLE, {1'b0, 18'($urandom), 5'($urandom), x});
  endtask

  task automatic send_coeff(input logic [4:0] idx, input logic signed [17:0] value);
    send_word(KIND_COEFF, {1'b0, value, idx, 16'($urandom)});
  endtask

  // Drop valid, wait for every outstanding word, then let a coefficient write
  // or a trailing sample finish before touching the registers.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IW-1:0] idx, input logic [17:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [5:0] taps, input logic signed [17:0] b0,
                               input logic signed [17:0] b1, input logic signed [17:0] b2,
                               input logic signed [17:0] a1, input logic signed [17:0] a2,
                               input logic [16:0] gain);
    wait_drained();
    put_reg(REG_UNUSED, 18'($urandom));
    put_reg(REG_TAPS, {12'($urandom), taps});
    put_reg(REG_B0, b0);
    put_reg(REG_B1, b1);
    put_reg(REG_B2, b2);
    put_reg(REG_A1, a1);
    put_reg(REG_A2, a2);
    put_reg(REG_GAIN, {1'($urandom), gain});
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_settings();
    logic [5:0]         taps;
    logic signed [17:0] b0, b1, b2, a1, a2;
    logic [16:0]        gain;
    case ($urandom_range(9))
      0, 1, 2, 3: taps = '0;
      8:          taps = 6'($urandom_range(63, 33));
      9:          taps = ($urandom_range(1) != 0) ? 6'd1 : 6'd32;
      default:    taps = 6'($urandom_range(32, 1));
    endcase
    b0 = 18'($urandom);
    b1 = 18'($urandom);
    b2 = 18'($urandom);
    // half the time keep |a1| + |a2| at or below one so the section stays stable
    if ($urandom_range(1) != 0) begin
      a1 = 18'($urandom_range(16383)) - 18'sd8192;
      a2 = 18'($urandom_range(16383)) - 18'sd8192;
    end else begin
      a1 = 18'($urandom);
      a2 = 18'($urandom);
    end
    case ($urandom_range(3))
      0:       gain = 17'd16384;
      1:       gain = 17'h1ffff;
      2:       gain = 17'($urandom_range(4096));
      default: gain = 17'($urandom);
    endcase
    load_settings(taps, b0, b1, b2, a1, a2, gain);
  endtask

  task automatic random_item();
    logic signed [15:0] x;
    if ($urandom_range(99) < 15) begin
      send_coeff(5'($urandom), 18'($urandom));
    end else begin
      case ($urandom_range(9))
        0:       x = 16'sh7fff;
        1:       x = 16'sh8000;
        2:       x = 16'($urandom_range(63)) - 16'd32;
        default: x = 16'($urandom);
      endcase
      send_sample(x);
    end
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser <= KIND_SAMPLE;
    s_tdata <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_TAPS;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: biquad passing w through b2, a two-sample delay
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sd0);
    send_sample(16'sd1);

    // extreme coefficients and gain drive w and the output into saturation
    load_settings(6'd0, 18'sh1ffff, 18'sh20000, 18'sh1ffff, 18'sh20000, 18'sh1ffff,
                  17'h1ffff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sd100);

    // full FIR with coefficients at both ends of the line
    load_settings(6'd32, 18'sd16384, 18'sd0, 18'sd16384, 18'sd0, 18'sd0, 17'd16384);
    send_coeff(5'd0, 18'sh1ffff);
    send_coeff(5'd31, 18'sh20000);
    send_coeff(5'd7, -18'sd5000);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sd1234);

    // tap count above the line length is capped
    load_settings(6'd63, 18'sd16384, 18'sd0, 18'sd16384, 18'sd0, 18'sd0, 17'h1ffff);
    send_sample(16'sh8000);
    send_sample(16'sh8000);

    // shrink the tap count: the tail of the line must hold its samples
    load_settings(6'd3, 18'sd16384, 18'sd0, 18'sd16384, 18'sd0, 18'sd0, 17'd16384);
    send_sample(16'sd500);
    send_sample(-16'sd700);
    load_settings(6'd1, 18'sd16384, 18'sd0, 18'sd16384, 18'sd0, 18'sd0, 17'd16384);
    send_sample(16'sh7fff);

    // back to the biquad: its state survived the FIR run
    load_settings(6'd0, 18'sd0, 18'sd16384, 18'sd0, 18'sd0, 18'sd0, 17'd16384);
    send_sample(16'sd10);
    send_sample(16'sd20);
    load_settings(6'd0, 18'sd0, 18'sd16384, 18'sd0, 18'sd0, 18'sd0, 17'd0);
    send_sample(16'sh7fff);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 6) begin
        send_idle_pct = 48;
        recv_idle_pct = 8;
      end else if (phase == 11) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_settings();
      repeat (PHASE_ITEMS) random_item();
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ iir_biquad_or_fir_filter_core.f @@
design/bqf_pkg.sv
design/bqf_ram.sv
design/bqf_mac.sv
design/iir_biquad_or_fir_filter_core.sv
verif/bqf_filter_checker.sv
verif/iir_biquad_or_fir_filter_core_test.sv
